>>> rtl/core/msb_pkg.sv
// Package for the multiset bag store: operation, status and state types,
// item format between front and back, and IEEE-754 equality helper.
// No dependencies.
package msb_pkg;

    localparam int VAL_W   = 64;
    localparam int KIND_W  = 3;
    localparam int CNT_O_W = 7;

    // Input kind codes
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_POP,
        OP_REMOVE,
        OP_CLEAR,
        OP_QUERY,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_POP,
        B_SCAN,
        B_MOVE_RD,
        B_MOVE_WR
    } back_state_t;

    // Classified item as held in the queue
    typedef struct packed {
        op_t               op;
        logic [VAL_W-1:0]  value;
        logic              val_nan;
        logic              val_zero;
    } cmd_t;

    function automatic logic is_nan(input logic [VAL_W-1:0] a);
        is_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    endfunction

    function automatic logic is_zero(input logic [VAL_W-1:0] a);
        is_zero = (a[62:0] == 63'd0);
    endfunction

    // IEEE equality of a stored entry with a pre-classified value
    function automatic logic fp_match(input logic [VAL_W-1:0] entry,
                                      input logic [VAL_W-1:0] value,
                                      input logic             val_nan,
                                      input logic             val_zero);
        if (val_nan || is_nan(entry))
            fp_match = 1'b0;
        else if (val_zero && is_zero(entry))
            fp_match = 1'b1;
        else
            fp_match = (entry == value);
    endfunction

endpackage

>>> rtl/core/msb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msb_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/msb_front.sv
// Front end: accepts items, classifies kind and value, and holds them in
// a two-entry queue for the back end. Depends on msb_pkg.
module msb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [msb_pkg::KIND_W-1:0]    kind,
    input  logic [msb_pkg::VAL_W-1:0]     value,
    output logic                          q_valid,
    output msb_pkg::cmd_t                 q_head,
    input  logic                          q_pop
);
    import msb_pkg::*;

    cmd_t        slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    cmd_t        cmd_in;

    // classify the incoming item
    always_comb
    begin
        case (kind)
            KIND_ADD:    cmd_in.op = OP_ADD;
            KIND_POP:    cmd_in.op = OP_POP;
            KIND_REMOVE: cmd_in.op = OP_REMOVE;
            KIND_CLEAR:  cmd_in.op = OP_CLEAR;
            KIND_QUERY:  cmd_in.op = OP_QUERY;
            default:     cmd_in.op = OP_NONE;
        endcase
        cmd_in.value    = value;
        cmd_in.val_nan  = is_nan(value);
        cmd_in.val_zero = is_zero(value);
    end

    assign busy    = (fill_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (fill_reg != 2'd0);
    assign q_head  = slot_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        fill_next   = fill_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

>>> rtl/core/msb_back.sv
// Back end: executes queued items against the entry RAM, scanning one
// entry per cycle for remove and query. Depends on msb_pkg, msb_ram.
module msb_back #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  msb_pkg::cmd_t                 q_head,
    output logic                          q_pop,
    output logic                          done,
    output logic [msb_pkg::VAL_W-1:0]     popped_value,
    output logic [1:0]                    status,
    output logic [msb_pkg::CNT_O_W-1:0]   frequency,
    output logic                          found,
    output logic [msb_pkg::CNT_O_W-1:0]   entry_count,
    output logic                          is_empty
);
    import msb_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic               chk_reg, chk_next;
    logic [AW-1:0]      chk_idx_reg, chk_idx_next;
    logic [AW-1:0]      hit_idx_reg, hit_idx_next;
    logic [CW-1:0]      freq_reg, freq_next;

    logic               done_reg, done_next;
    logic [VAL_W-1:0]   popped_reg, popped_next;
    status_t            status_reg, status_next;
    logic [CNT_O_W-1:0] freqo_reg, freqo_next;
    logic               found_reg, found_next;
    logic [CNT_O_W-1:0] cnto_reg, cnto_next;
    logic               empty_reg, empty_next;

    logic [CW-1:0]      last_idx;
    logic               issue;
    logic               hit;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VAL_W-1:0]   wr_data;
    logic [AW-1:0]      rd_addr;
    logic [VAL_W-1:0]   rd_data;

    msb_ram #(
        .WIDTH  (VAL_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign last_idx = count_reg - CW'(1);
    assign issue    = (rd_idx_reg < count_reg);
    assign hit      = chk_reg && fp_match(rd_data, cmd_reg.value,
                                          cmd_reg.val_nan, cmd_reg.val_zero);

    // next state, RAM control and result
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        chk_next     = 1'b0;
        chk_idx_next = chk_idx_reg;
        hit_idx_next = hit_idx_reg;
        freq_next    = freq_reg;
        q_pop        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = count_reg[AW-1:0];
        wr_data      = q_head.value;
        rd_addr      = last_idx[AW-1:0];
        done_next    = 1'b0;
        popped_next  = '0;
        status_next  = ST_OK;
        freqo_next   = '0;
        found_next   = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    case (q_head.op)
                        OP_ADD:
                        begin
                            done_next = 1'b1;
                            if (count_reg < CW'(CAPACITY))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                                status_next = ST_FULL;
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                                state_next = B_POP;
                        end
                        OP_REMOVE, OP_QUERY:
                        begin
                            rd_idx_next = '0;
                            freq_next   = '0;
                            state_next  = B_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // last entry read was issued in the dispatch cycle
            B_POP:
            begin
                done_next   = 1'b1;
                popped_next = rd_data;
                count_next  = last_idx;
                state_next  = B_IDLE;
            end

            // one read issued and one entry compared per cycle
            B_SCAN:
            begin
                rd_addr = rd_idx_reg[AW-1:0];
                if (hit)
                    freq_next = freq_reg + CW'(1);
                if (hit && cmd_reg.op == OP_REMOVE)
                begin
                    hit_idx_next = chk_idx_reg;
                    state_next   = B_MOVE_RD;
                end
                else if (!issue && !chk_reg)
                begin
                    done_next  = 1'b1;
                    state_next = B_IDLE;
                    if (cmd_reg.op == OP_REMOVE)
                        status_next = ST_NOT_FOUND;
                    else
                    begin
                        freqo_next = CNT_O_W'(freq_reg);
                        found_next = (freq_reg != '0);
                    end
                end
                else
                begin
                    chk_next     = issue;
                    chk_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next  = rd_idx_reg + CW'(issue);
                end
            end

            B_MOVE_RD:
            begin
                state_next = B_MOVE_WR;
            end

            // last entry fills the hole
            B_MOVE_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = hit_idx_reg;
                wr_data    = rd_data;
                count_next = last_idx;
                done_next  = 1'b1;
                found_next = 1'b1;
                state_next = B_IDLE;
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        cnto_next  = CNT_O_W'(count_next);
        empty_next = (count_next == '0);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            count_reg <= '0;
            chk_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            chk_reg   <= chk_next;
            done_reg  <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        hit_idx_reg <= hit_idx_next;
        freq_reg    <= freq_next;
        popped_reg  <= popped_next;
        status_reg  <= status_next;
        freqo_reg   <= freqo_next;
        found_reg   <= found_next;
        cnto_reg    <= cnto_next;
        empty_reg   <= empty_next;
    end

    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign frequency    = freqo_reg;
    assign found        = found_reg;
    assign entry_count  = cnto_reg;
    assign is_empty     = empty_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == ST_FULL |-> count_reg == CW'(CAPACITY))
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == ST_EMPTY |-> empty_reg)
        else $error("pop-empty status on a non-empty bag");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && found_reg |-> status_reg == ST_OK)
        else $error("found flag with error status");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_MOVE_WR |=> count_reg == $past(count_reg) - CW'(1))
        else $error("remove did not shrink the bag");

endmodule

>>> rtl/core/multiset_bag_store_core.sv
// Top level of the multiset bag store: front end with item queue and
// back end with entry RAM. Depends on msb_pkg, msb_front, msb_back.
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+--------------------
//  item in   | kind, value                              | start & !busy
//  result    | popped_value, status, frequency, found,  | done, one cycle
//            | entry_count, is_empty                    |
//
// With the back end idle, add, clear, pop on empty and unknown kinds answer
// straight from the dispatch state; pop with entries answers from B_POP. Remove
// and query scan the RAM one entry per cycle through its single read port; a
// query or a missed removal scans every entry, and a removal that hits entry i
// stops there and moves the last entry through B_MOVE_RD and B_MOVE_WR.
// A two-entry queue lets up to two items wait; busy is high while it is full.
// Reset empties the bag; the RAM contents need no clearing.
// Results cannot be stalled: each is shown for exactly one cycle.
module multiset_bag_store_core #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [msb_pkg::KIND_W-1:0]    kind,
    input  logic [msb_pkg::VAL_W-1:0]     value,
    output logic                          done,
    output logic [msb_pkg::VAL_W-1:0]     popped_value,
    output logic [1:0]                    status,
    output logic [msb_pkg::CNT_O_W-1:0]   frequency,
    output logic                          found,
    output logic [msb_pkg::CNT_O_W-1:0]   entry_count,
    output logic                          is_empty
);
    import msb_pkg::*;

    logic q_valid;
    cmd_t q_head;
    logic q_pop;

    msb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .kind    (kind),
        .value   (value),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    msb_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .done         (done),
        .popped_value (popped_value),
        .status       (status),
        .frequency    (frequency),
        .found        (found),
        .entry_count  (entry_count),
        .is_empty     (is_empty)
    );

endmodule

>>> tb/tb_multiset_bag_store_core.sv
// Self-checking testbench for multiset_bag_store_core: random and directed bag items,
// results predicted in a local bag model and compared field by field.
// Depends on msb_pkg and multiset_bag_store_core.
module tb_multiset_bag_store_core;

    import msb_pkg::*;

    localparam int BAG_DEPTH    = 64;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 750;
    localparam int REPORT_MAX   = 10;

    // Kind codes the block does not decode
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

    // Notable double bit patterns
    localparam logic [VAL_W-1:0] DBL_POS_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [VAL_W-1:0] DBL_NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [VAL_W-1:0] DBL_POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [VAL_W-1:0] DBL_NEG_INF  = 64'hFFF0_0000_0000_0000;
    localparam logic [VAL_W-1:0] DBL_QNAN     = 64'h7FF8_0000_0000_0000;
    localparam logic [VAL_W-1:0] DBL_SNAN     = 64'h7FF0_0000_0000_0001;
    localparam logic [VAL_W-1:0] DBL_ONE      = 64'h3FF0_0000_0000_0000;
    localparam logic [VAL_W-1:0] DBL_NEG_2P5  = 64'hC004_0000_0000_0000;
    localparam logic [VAL_W-1:0] DBL_MAX      = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] DBL_TINY     = 64'h0000_0000_0000_0001;
    localparam logic [VAL_W-1:0] DBL_NEG_TINY = 64'h8000_0000_0000_0001;
    localparam logic [VAL_W-1:0] DBL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  value;
        logic [1:0]        gap;
    } bag_item_t;

    typedef struct packed {
        logic [VAL_W-1:0]   popped;
        status_t            status;
        logic [CNT_O_W-1:0] freq;
        logic               hit;
        logic [CNT_O_W-1:0] count;
        logic               empty;
    } bag_result_t;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [KIND_W-1:0]    kind  = '0;
    logic [VAL_W-1:0]     value = '0;
    logic                 busy;
    logic                 done;
    logic [VAL_W-1:0]     popped_value;
    logic [1:0]           status;
    logic [CNT_O_W-1:0]   frequency;
    logic                 found;
    logic [CNT_O_W-1:0]   entry_count;
    logic                 is_empty;

    bag_item_t   pending_items[$];
    bag_result_t predicted_results[$];
    bag_item_t   next_item;
    bag_result_t oldest_result;

    // Local copy of the bag contents
    logic [VAL_W-1:0] bag_words [BAG_DEPTH];
    int               bag_fill = 0;

    logic [1:0] gap_left     = '0;
    int         mismatches   = 0;
    int         stall_cycles = 0;
    bit         steady_flow  = 1'b0;
    int         issued       = 0;

    wire item_taken = start && !busy;

    multiset_bag_store_core #(
        .CAPACITY     (BAG_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .value        (value),
        .done         (done),
        .popped_value (popped_value),
        .status       (status),
        .frequency    (frequency),
        .found        (found),
        .entry_count  (entry_count),
        .is_empty     (is_empty)
    );

    always #2 clk = ~clk;

    // IEEE-754 equality on raw bit patterns
    function automatic logic same_double(input logic [VAL_W-1:0] a,
                                         input logic [VAL_W-1:0] b);
        logic a_nan;
        logic b_nan;
        a_nan = (&a[62:52]) && (|a[51:0]);
        b_nan = (&b[62:52]) && (|b[51:0]);
        if (a_nan || b_nan)
            return 1'b0;
        if ((a[62:0] | b[62:0]) == 63'd0)
            return 1'b1;
        return a == b;
    endfunction

    // Apply one item to the local bag and queue the result it should give
    task automatic apply_bag_op(input logic [KIND_W-1:0] k, input logic [VAL_W-1:0] v);
        bag_result_t r;
        int          i;
        int          hits;
        r        = '0;
        r.status = ST_OK;
        hits     = 0;
        case (k)
            KIND_ADD:
                if (bag_fill < BAG_DEPTH)
                begin
                    bag_words[bag_fill] = v;
                    bag_fill++;
                end
                else
                    r.status = ST_FULL;
            KIND_POP:
                if (bag_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    bag_fill--;
                    r.popped = bag_words[bag_fill];
                end
            KIND_REMOVE:
            begin
                r.status = ST_NOT_FOUND;
                // first match takes the last entry; loop stops once hit is set
                for (i = 0; i < bag_fill && !r.hit; i++)
                begin
                    if (same_double(bag_words[i], v))
                    begin
                        bag_words[i] = bag_words[bag_fill - 1];
                        bag_fill--;
                        r.hit    = 1'b1;
                        r.status = ST_OK;
                    end
                end
            end
            KIND_CLEAR:
                bag_fill = 0;
            KIND_QUERY:
            begin
                for (i = 0; i < bag_fill; i++)
                    if (same_double(bag_words[i], v))
                        hits++;
                r.freq = hits[CNT_O_W-1:0];
                r.hit  = (hits != 0);
            end
            default: ;
        endcase
        r.count = bag_fill[CNT_O_W-1:0];
        r.empty = (bag_fill == 0);
        predicted_results.push_back(r);
    endtask

    // Reset, held low at the start and then released
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: presents pending items, predicts each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            kind     <= '0;
            value    <= '0;
            gap_left <= '0;
        end
        else
        begin
            if (item_taken)
                apply_bag_op(kind, value);
            if (!start || item_taken)
            begin
                if (gap_left != 0)
                begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 2'd1;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    start    <= 1'b1;
                    kind     <= next_item.kind;
                    value    <= next_item.value;
                    gap_left <= next_item.gap;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic flag_field(input string name, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Monitor: every strobed result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result with nothing predicted: status %0d count %0d",
                             status, entry_count);
            end
            else
            begin
                oldest_result = predicted_results.pop_front();
                flag_field("popped_value", oldest_result.popped, popped_value);
                flag_field("status", oldest_result.status, status);
                flag_field("frequency", oldest_result.freq, frequency);
                flag_field("found", oldest_result.hit, found);
                flag_field("entry_count", oldest_result.count, entry_count);
                flag_field("is_empty", oldest_result.empty, is_empty);
            end
        end
    end

    // Watchdog: too long with no item taken and no result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_taken || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic [KIND_W-1:0] k, input logic [VAL_W-1:0] v);
        bag_item_t it;
        it.kind  = k;
        it.value = v;
        it.gap   = steady_flow ? 2'd0 : 2'($urandom_range(0, 3));
        pending_items.push_back(it);
        issued++;
    endtask

    // Mostly a small set of values so that queries and removals hit
    function automatic logic [VAL_W-1:0] pick_word();
        case ($urandom_range(0, 13))
            0:       return DBL_POS_ZERO;
            1:       return DBL_NEG_ZERO;
            2:       return DBL_POS_INF;
            3:       return DBL_NEG_INF;
            4:       return DBL_QNAN;
            5:       return DBL_SNAN;
            6:       return DBL_ONE;
            7:       return DBL_NEG_2P5;
            8:       return DBL_MAX;
            9:       return DBL_TINY;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] noise_word();
        return {$urandom, $urandom};
    endfunction

    // Random item with weighted kinds
    task automatic queue_mixed();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            queue_item(KIND_ADD, pick_word());
        else if (roll < 50)
            queue_item(KIND_POP, noise_word());
        else if (roll < 70)
            queue_item(KIND_REMOVE, pick_word());
        else if (roll < 90)
            queue_item(KIND_QUERY, pick_word());
        else if (roll < 93)
            queue_item(KIND_CLEAR, noise_word());
        else
            queue_item(3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C)), noise_word());
    endtask

    // Run up to near capacity and often past it, then poke at the bag
    task automatic queue_fill_run();
        int n;
        int i;
        n = $urandom_range(BAG_DEPTH - 4, BAG_DEPTH + 6);
        queue_item(KIND_CLEAR, noise_word());
        for (i = 0; i < n; i++)
            queue_item(KIND_ADD, pick_word());
        for (i = 0; i < 6; i++)
            queue_mixed();
    endtask

    // Stimulus and end of run
    initial
    begin
        int phase;
        int i;

        // Directed: empty bag, signed zeros, NaN, extremes, spare kinds
        queue_item(KIND_POP, DBL_ONES);
        queue_item(KIND_REMOVE, DBL_ONE);
        queue_item(KIND_QUERY, DBL_POS_ZERO);
        queue_item(KIND_ADD, DBL_POS_ZERO);
        queue_item(KIND_ADD, DBL_NEG_ZERO);
        queue_item(KIND_ADD, DBL_QNAN);
        queue_item(KIND_ADD, DBL_ONES);
        queue_item(KIND_ADD, DBL_MAX);
        queue_item(KIND_ADD, DBL_ONE);
        queue_item(KIND_QUERY, DBL_NEG_ZERO);
        queue_item(KIND_QUERY, DBL_QNAN);
        queue_item(KIND_QUERY, DBL_MAX);
        queue_item(KIND_REMOVE, DBL_NEG_ZERO);
        queue_item(KIND_REMOVE, DBL_QNAN);
        queue_item(KIND_ADD, DBL_NEG_TINY);
        queue_item(KIND_QUERY, DBL_POS_ZERO);
        queue_item(KIND_POP, DBL_POS_ZERO);
        queue_item(KIND_SPARE_A, DBL_ONES);
        queue_item(KIND_SPARE_B, DBL_ONES);
        queue_item(KIND_SPARE_C, DBL_ONES);
        queue_item(KIND_CLEAR, DBL_ONES);
        queue_item(KIND_POP, DBL_POS_ZERO);
        queue_item(KIND_QUERY, DBL_POS_INF);

        // Random: a fill run first, then mixed, fill and drain phases
        issued = 0;
        queue_fill_run();
        while (issued < RANDOM_ITEMS)
        begin
            steady_flow = ($urandom_range(0, 3) == 0);
            phase = $urandom_range(0, 5);
            if (phase == 0)
                queue_fill_run();
            else if (phase == 1)
            begin
                // drain with pops and removals
                for (i = 0; i < 20; i++)
                    if ($urandom_range(0, 1) == 0)
                        queue_item(KIND_POP, noise_word());
                    else
                        queue_item(KIND_REMOVE, pick_word());
            end
            else
                for (i = 0; i < 30; i++)
                    queue_mixed();
        end

        // Wait for every item to be taken and answered
        while (pending_items.size() != 0 || start || predicted_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && predicted_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
